// ----- sv/dket_pkg.sv -----
// ----------------------------------------------------------------------------
// dket_pkg
// Shared types and codes for the dual-key entity table.
// ----------------------------------------------------------------------------
package dket_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int CFG_AW            = 3;
  localparam int CFG_DW            = 32;

  localparam logic [2:0] REQ_ADD      = 3'd0;
  localparam logic [2:0] REQ_RESTORE  = 3'd1;
  localparam logic [2:0] REQ_REM_ID   = 3'd2;
  localparam logic [2:0] REQ_REM_KEY  = 3'd3;
  localparam logic [2:0] REQ_ZONE     = 3'd4;
  localparam logic [2:0] REQ_LOOK_ID  = 3'd5;
  localparam logic [2:0] REQ_LOOK_KEY = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REJECT    = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_WRAPPED   = 3'd4;

  localparam logic [CFG_AW-3:0] REG_GENERATION = '0;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] key;
    logic [15:0] profile;
    logic [31:0] zone;
    logic [31:0] generation;
    logic [31:0] flags;
  } rec_t;

  typedef struct packed {
    logic id_hit;
    logic key_hit;
    logic free_hit;
  } hit_t;

endpackage

// ----- sv/dket_ram.sv -----
// ----------------------------------------------------------------------------
// dket_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/dket_scan.sv -----
// ----------------------------------------------------------------------------
// dket_scan
// Compare unit: per-slot id and key match, first hits and first free slot.
// ----------------------------------------------------------------------------
module dket_scan #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic                             cmp_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] cmp_idx,
  input  logic                             cmp_valid,
  input  dket_pkg::rec_t                   cmp_rec,
  input  logic [63:0]                      id_tgt,
  input  logic [63:0]                      key_tgt,
  output dket_pkg::hit_t                   hits,
  output logic [$clog2(TABLE_ENTRIES)-1:0] id_slot,
  output logic [$clog2(TABLE_ENTRIES)-1:0] key_slot,
  output logic [$clog2(TABLE_ENTRIES)-1:0] free_slot,
  output dket_pkg::rec_t                   id_rec,
  output dket_pkg::rec_t                   key_rec
);
  import dket_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);

  hit_t          hits_r;
  logic [IW-1:0] id_slot_r;
  logic [IW-1:0] key_slot_r;
  logic [IW-1:0] free_slot_r;
  rec_t          id_rec_r;
  rec_t          key_rec_r;
  logic          id_eq;
  logic          key_eq;

  assign id_eq  = cmp_valid && (cmp_rec.id == id_tgt);
  assign key_eq = cmp_valid && (cmp_rec.key == key_tgt);

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hits_r <= '0;
    end else if (cmp_en) begin
      if (id_eq && !hits_r.id_hit) begin
        hits_r.id_hit <= 1'b1;
      end
      if (key_eq && !hits_r.key_hit) begin
        hits_r.key_hit <= 1'b1;
      end
      if (!cmp_valid && !hits_r.free_hit) begin
        hits_r.free_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (id_eq && !hits_r.id_hit) begin
        id_slot_r <= cmp_idx;
        id_rec_r  <= cmp_rec;
      end
      if (key_eq && !hits_r.key_hit) begin
        key_slot_r <= cmp_idx;
        key_rec_r  <= cmp_rec;
      end
      if (!cmp_valid && !hits_r.free_hit) begin
        free_slot_r <= cmp_idx;
      end
    end
  end

  assign hits      = hits_r;
  assign id_slot   = id_slot_r;
  assign key_slot  = key_slot_r;
  assign free_slot = free_slot_r;
  assign id_rec    = id_rec_r;
  assign key_rec   = key_rec_r;

endmodule

// ----- sv/dual_key_entity_table_top.sv -----
// ----------------------------------------------------------------------------
// dual_key_entity_table_top
// Entity table searchable by 64-bit id or 64-bit local key.
//
//   channel  | handshake          | word
//   in_      | in_valid/in_ready  | request and record fields
//   out_     | out_valid/out_ready| status and record fields
//   APB      | psel/penable/...   | generation register at offset 0
//
// Each request makes one full pass of the record RAM read port (one slot a
// cycle) plus issue, compare and commit steps.
// rst_n is synchronous; it empties the table and sets the index counter to 1.
// in_ready is low while a request is in work; a stalled result holds the
// commit cycle until out_ready frees the output register.
// ----------------------------------------------------------------------------
module dual_key_entity_table_top #(
  parameter int TABLE_ENTRIES = dket_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_req_type,
  input  logic [63:0]                 in_entity_id,
  input  logic [63:0]                 in_local_key,
  input  logic [15:0]                 in_profile,
  input  logic [31:0]                 in_zone,
  input  logic [31:0]                 in_record_generation,
  input  logic [31:0]                 in_replication_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [63:0]                 out_res_id,
  output logic [63:0]                 out_res_key,
  output logic [15:0]                 out_res_profile,
  output logic [31:0]                 out_res_zone,
  output logic [31:0]                 out_res_generation,
  output logic [31:0]                 out_res_flags,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dket_pkg::CFG_AW-1:0] paddr,
  input  logic [dket_pkg::CFG_DW-1:0] pwdata,
  output logic [dket_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import dket_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [IW-1:0]            cnt_r;
  logic                     cmp_en_r;
  logic [IW-1:0]            cmp_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]              gen_cfg_r;
  logic [31:0]              next_index_r;

  logic [2:0]  req_r;
  logic [63:0] id_r;
  logic [63:0] key_r;
  logic [15:0] prof_r;
  logic [31:0] zone_r;
  logic [31:0] rgen_r;
  logic [31:0] flags_r;

  logic        out_valid_r;
  logic [2:0]  status_r;
  rec_t        out_rec_r;

  logic        accept;
  logic        commit;
  logic [31:0] gen;
  logic [63:0] nid;
  logic [63:0] id_tgt;
  rec_t        rdata;
  hit_t        hits;
  logic [IW-1:0] id_slot, key_slot, free_slot;
  rec_t        id_rec, key_rec;

  logic          we;
  logic [IW-1:0] waddr;
  rec_t          wdata;
  logic [2:0]    status_nxt;
  rec_t          rec_nxt;
  logic [31:0]   next_index_nxt;
  logic          clr_en;
  logic [IW-1:0] clr_slot;
  logic          set_en;
  logic [31:0]   ridx;
  logic [31:0]   rni;

  assign pready   = 1'b1;
  assign prdata   = (paddr[CFG_AW-1:2] == REG_GENERATION) ? gen_cfg_r : '0;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_DECIDE) && (!out_valid_r || out_ready);
  assign gen      = (gen_cfg_r == 32'd0) ? 32'd1 : gen_cfg_r;
  assign nid      = {gen, next_index_r};
  assign id_tgt   = (req_r == REQ_ADD) ? nid : id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_cfg_r <= 32'd1;
    end else if (psel && penable && pwrite && paddr[CFG_AW-1:2] == REG_GENERATION) begin
      gen_cfg_r <= pwdata;
    end
  end

  dket_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  dket_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (accept),
    .cmp_en    (cmp_en_r),
    .cmp_idx   (cmp_idx_r),
    .cmp_valid (valid_r[cmp_idx_r]),
    .cmp_rec   (rdata),
    .id_tgt    (id_tgt),
    .key_tgt   (key_r),
    .hits      (hits),
    .id_slot   (id_slot),
    .key_slot  (key_slot),
    .free_slot (free_slot),
    .id_rec    (id_rec),
    .key_rec   (key_rec)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (cnt_r == IW'(TABLE_ENTRIES - 1)) state_nxt = S_LAST;
      S_LAST:   state_nxt = S_DECIDE;
      S_DECIDE: if (commit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cmp_en_r <= (state_r == S_SCAN);
      if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r;
    if (accept) begin
      req_r   <= in_req_type;
      id_r    <= in_entity_id;
      key_r   <= in_local_key;
      prof_r  <= in_profile;
      zone_r  <= in_zone;
      rgen_r  <= in_record_generation;
      flags_r <= in_replication_flags;
    end
  end

  assign ridx = id_r[31:0];
  assign rni  = (ridx >= next_index_r) ? ridx + 32'd1 : next_index_r;

  always_comb begin
    status_nxt     = ST_REJECT;
    rec_nxt        = '0;
    next_index_nxt = next_index_r;
    we             = 1'b0;
    waddr          = free_slot;
    wdata          = '0;
    clr_en         = 1'b0;
    clr_slot       = id_slot;
    set_en         = 1'b0;
    case (req_r)
      REQ_ADD: begin
        wdata = '{id: nid, key: key_r, profile: prof_r, zone: zone_r,
                  generation: gen, flags: flags_r};
        if (key_r == 64'd0 || zone_r == 32'd0 || hits.key_hit) begin
          status_nxt = ST_REJECT;
        end else if (next_index_r == 32'd0 || next_index_r == '1) begin
          status_nxt = ST_EXHAUSTED;
        end else if (hits.id_hit) begin
          status_nxt = ST_REJECT;
        end else if (!hits.free_hit) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt     = ST_OK;
          we             = 1'b1;
          set_en         = 1'b1;
          rec_nxt        = wdata;
          next_index_nxt = next_index_r + 32'd1;
        end
      end
      REQ_RESTORE: begin
        wdata = '{id: id_r, key: key_r, profile: prof_r, zone: zone_r,
                  generation: rgen_r, flags: flags_r};
        if (id_r == 64'd0 || key_r == 64'd0 || zone_r == 32'd0 ||
            ridx == 32'd0 || id_r[63:32] != gen || rgen_r != id_r[63:32] ||
            hits.id_hit || hits.key_hit) begin
          status_nxt = ST_REJECT;
        end else if (!hits.free_hit) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt     = (rni == 32'd0) ? ST_WRAPPED : ST_OK;
          we             = 1'b1;
          set_en         = 1'b1;
          rec_nxt        = wdata;
          next_index_nxt = rni;
        end
      end
      REQ_REM_ID: begin
        if (hits.id_hit) begin
          status_nxt = ST_OK;
          rec_nxt    = id_rec;
          clr_en     = 1'b1;
        end
      end
      REQ_REM_KEY: begin
        clr_slot = key_slot;
        if (hits.key_hit) begin
          status_nxt = ST_OK;
          rec_nxt    = key_rec;
          clr_en     = 1'b1;
        end
      end
      REQ_ZONE: begin
        waddr      = id_slot;
        wdata      = id_rec;
        wdata.zone = zone_r;
        if (zone_r != 32'd0 && hits.id_hit) begin
          status_nxt = ST_OK;
          we         = 1'b1;
          rec_nxt    = wdata;
        end
      end
      REQ_LOOK_ID: begin
        if (hits.id_hit) begin
          status_nxt = ST_OK;
          rec_nxt    = id_rec;
        end
      end
      REQ_LOOK_KEY: begin
        if (hits.key_hit) begin
          status_nxt = ST_OK;
          rec_nxt    = key_rec;
        end
      end
      default: status_nxt = ST_REJECT;
    endcase
    if (!commit) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      next_index_r <= 32'd1;
      out_valid_r  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r  <= 1'b1;
        next_index_r <= next_index_nxt;
        if (set_en) begin
          valid_r[free_slot] <= 1'b1;
        end
        if (clr_en) begin
          valid_r[clr_slot] <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r  <= status_nxt;
      out_rec_r <= rec_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_res_id         = out_rec_r.id;
  assign out_res_key        = out_rec_r.key;
  assign out_res_profile    = out_rec_r.profile;
  assign out_res_zone       = out_rec_r.zone;
  assign out_res_generation = out_rec_r.generation;
  assign out_res_flags      = out_rec_r.flags;

endmodule

// ----- sv/dket_checker.sv -----
// ----------------------------------------------------------------------------
// dket_checker
// Port-level checks for the dual-key entity table, bound to the top level.
// ----------------------------------------------------------------------------
module dket_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [63:0] out_res_id,
  input logic [63:0] out_res_key,
  input logic [31:0] out_res_zone
);
  import dket_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REJECT || out_status == ST_EXHAUSTED ||
                  out_status == ST_FULL) |-> out_res_id == 64'd0 && out_res_key == 64'd0)
    else $error("failed result carries a record");

  a_ok_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_WRAPPED) |-> out_res_zone != 32'd0)
    else $error("successful result with zero zone");

endmodule

bind dual_key_entity_table_top dket_checker u_dket_checker (.*);

// ----- verif/tb_dual_key_entity_table_top.sv -----
// ----------------------------------------------------------------------------
// tb_dual_key_entity_table_top
// Self-checking bench for the dual-key entity table: a scoreboard class keeps
// its own copy of the table, the index counter and the generation register,
// predicts the word for every accepted request and compares each result word
// field by field. Stimulus mixes directed corner cases, well-formed add,
// restore, remove, zone and lookup sequences, noise, and random handshake
// idling, including a long output hold-off that stalls the next request at commit.
// ----------------------------------------------------------------------------
module tb_dual_key_entity_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dket_pkg::*;

  localparam int ENTRIES = 64;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [2:0]  status;
    rec_t        rec;
  } result_t;

  class entity_scoreboard;
    bit          valid_q[ENTRIES];
    rec_t        slots[ENTRIES];
    logic [31:0] next_index;
    logic [31:0] generation;
    result_t     pending[$];
    int          errors;
    int          checked;

    function void clear();
      foreach (valid_q[i]) valid_q[i] = 0;
      next_index = 32'd1;
      generation = 32'd1;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function int find_id(logic [63:0] id);
      for (int i = 0; i < ENTRIES; i++)
        if (valid_q[i] && slots[i].id == id) return i;
      return -1;
    endfunction

    function int find_key(logic [63:0] key);
      for (int i = 0; i < ENTRIES; i++)
        if (valid_q[i] && slots[i].key == key) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < ENTRIES; i++)
        if (!valid_q[i]) return i;
      return -1;
    endfunction

    function void note_request(logic [2:0] req, logic [63:0] id, logic [63:0] key,
                               logic [15:0] prof, logic [31:0] zone,
                               logic [31:0] rgen, logic [31:0] flags);
      logic [31:0] gen;
      logic [63:0] nid;
      result_t r;
      int s;
      gen = (generation == 0) ? 32'd1 : generation;
      r = '0;
      r.status = ST_REJECT;
      s = -1;
      case (req)
        REQ_ADD: begin
          if (key != 0 && zone != 0 && find_key(key) < 0) begin
            if (next_index == 0 || next_index == '1) r.status = ST_EXHAUSTED;
            else begin
              nid = {gen, next_index};
              if (find_id(nid) < 0) begin
                s = find_free();
                if (s < 0) r.status = ST_FULL;
                else begin
                  valid_q[s] = 1;
                  slots[s] = '{nid, key, prof, zone, gen, flags};
                  next_index++;
                  r.status = ST_OK;
                end
              end
            end
          end
        end
        REQ_RESTORE: begin
          if (id != 0 && key != 0 && zone != 0 && id[31:0] != 0 && id[63:32] == gen &&
              rgen == id[63:32] && find_id(id) < 0 && find_key(key) < 0) begin
            s = find_free();
            if (s < 0) r.status = ST_FULL;
            else begin
              valid_q[s] = 1;
              slots[s] = '{id, key, prof, zone, rgen, flags};
              if (id[31:0] >= next_index) next_index = id[31:0] + 32'd1;
              r.status = (next_index == 0) ? ST_WRAPPED : ST_OK;
            end
          end
        end
        REQ_REM_ID, REQ_REM_KEY: begin
          s = (req == REQ_REM_ID) ? find_id(id) : find_key(key);
          if (s >= 0) begin
            r.status = ST_OK;
            r.rec = slots[s];
            valid_q[s] = 0;
            s = -1;
          end
        end
        REQ_ZONE: begin
          if (zone != 0) begin
            s = find_id(id);
            if (s >= 0) begin
              slots[s].zone = zone;
              r.status = ST_OK;
            end
          end
        end
        REQ_LOOK_ID: begin
          s = find_id(id);
          if (s >= 0) r.status = ST_OK;
        end
        REQ_LOOK_KEY: begin
          s = find_key(key);
          if (s >= 0) r.status = ST_OK;
        end
        default: ;
      endcase
      if ((r.status == ST_OK || r.status == ST_WRAPPED) && s >= 0) r.rec = slots[s];
      pending.push_back(r);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40) $display("mismatch %s: got %h want %h", what, got, want);
    endfunction

    function void check_result(result_t got);
      result_t w;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected word", 64'(got.status), 64'd0);
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
      if (got.rec.id !== w.rec.id) report("res_id", got.rec.id, w.rec.id);
      if (got.rec.key !== w.rec.key) report("res_key", got.rec.key, w.rec.key);
      if (got.rec.profile !== w.rec.profile)
        report("profile", 64'(got.rec.profile), 64'(w.rec.profile));
      if (got.rec.zone !== w.rec.zone)
        report("zone", 64'(got.rec.zone), 64'(w.rec.zone));
      if (got.rec.generation !== w.rec.generation)
        report("generation", 64'(got.rec.generation), 64'(w.rec.generation));
      if (got.rec.flags !== w.rec.flags)
        report("flags", 64'(got.rec.flags), 64'(w.rec.flags));
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [2:0] in_req_type = 0;
  logic [63:0] in_entity_id = 0, in_local_key = 0;
  logic [15:0] in_profile = 0;
  logic [31:0] in_zone = 0, in_record_generation = 0, in_replication_flags = 0;
  logic out_valid, out_ready = 0;
  logic [2:0] out_status;
  logic [63:0] out_res_id, out_res_key;
  logic [15:0] out_res_profile;
  logic [31:0] out_res_zone, out_res_generation, out_res_flags;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = 0;
  logic [CFG_DW-1:0] pwdata = 0, prdata;
  logic pready;

  entity_scoreboard sb;
  int in_idle_pct = 0, out_stall_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;
  int sent = 0;
  logic [63:0] used_keys[$];

  always #2 clk = ~clk;

  dual_key_entity_table_top dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_status, '{out_res_id, out_res_key, out_res_profile,
                        out_res_zone, out_res_generation, out_res_flags}});
    out_ready <= !hold_off && ($urandom_range(99) >= out_stall_pct);
  end

  task automatic write_generation(logic [31:0] value);
    psel <= 1; pwrite <= 1; paddr <= {REG_GENERATION, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.generation = value;
    @(posedge clk);
    if (prdata !== value) sb.report("prdata", 64'(prdata), 64'(value));
  endtask

  task automatic send(logic [2:0] req, logic [63:0] id, logic [63:0] key,
                      logic [15:0] prof, logic [31:0] zone, logic [31:0] rgen,
                      logic [31:0] flags);
    int idle;
    idle = 0;
    while ($urandom_range(99) < in_idle_pct) idle++;
    if (idle != 0) begin
      in_valid <= 0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1; in_req_type <= req; in_entity_id <= id; in_local_key <= key;
    in_profile <= prof; in_zone <= zone; in_record_generation <= rgen;
    in_replication_flags <= flags;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, id, key, prof, zone, rgen, flags);
    sent++;
    if (key != 0) used_keys.push_back(key);
    if (used_keys.size() > 80) void'(used_keys.pop_front());
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(3) != 0)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    return $urandom_range(3) == 0 ? rnd64() : 64'($urandom_range(200, 1));
  endfunction

  function automatic logic [63:0] pick_id();
    int s;
    if ($urandom_range(4) != 0) begin
      s = $urandom_range(ENTRIES - 1);
      if (sb.valid_q[s]) return sb.slots[s].id;
    end
    return $urandom_range(3) == 0 ? rnd64()
         : {(sb.generation == 0 ? 32'd1 : sb.generation), 32'($urandom_range(120))};
  endfunction

  task automatic random_item(bit noisy);
    logic [2:0] req;
    logic [31:0] gen;
    logic [63:0] id;
    gen = (sb.generation == 0) ? 32'd1 : sb.generation;
    req = 3'($urandom_range(noisy ? 7 : 6));
    id = pick_id();
    if (req == REQ_RESTORE && !noisy)
      id = {gen, ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(300, 1))};
    send(req, id, noisy ? rnd64() : pick_key(), 16'($urandom),
         noisy && $urandom_range(3) == 0 ? 32'd0 : $urandom | 32'd1,
         noisy ? $urandom : id[63:32], $urandom);
  endtask

  task automatic phase(int count, int idle, int stall);
    in_idle_pct = idle;
    out_stall_pct = stall;
    repeat (count) random_item($urandom_range(9) == 0);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(REQ_ADD, 0, 64'd5, 16'hFFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send(REQ_ADD, 0, 64'd0, 1, 1, 0, 0);
    send(REQ_ADD, 0, 64'd6, 1, 0, 0, 0);
    send(REQ_ADD, 0, 64'd5, 1, 1, 0, 0);
    send(REQ_ADD, 0, '1, 0, 1, 0, 0);
    send(REQ_RESTORE, {32'd1, 32'd40}, 64'd9, 16'h1234, 7, 1, 32'h5A5A_5A5A);
    send(REQ_RESTORE, {32'd2, 32'd41}, 64'd10, 1, 7, 2, 0);
    send(REQ_RESTORE, {32'd1, 32'd42}, 64'd10, 1, 7, 2, 0);
    send(REQ_RESTORE, {32'd1, 32'd0}, 64'd10, 1, 7, 1, 0);
    send(REQ_RESTORE, '1, 64'd10, 1, 7, 32'hFFFF_FFFF, 0);
    send(REQ_ADD, 0, 64'd11, 2, 3, 0, 1);
    send(REQ_ZONE, {32'd1, 32'd40}, 0, 0, 0, 0, 0);
    send(REQ_ZONE, {32'd1, 32'd40}, 0, 0, 32'd99, 0, 0);
    send(REQ_LOOK_ID, {32'd1, 32'd40}, 0, 0, 0, 0, 0);
    send(REQ_LOOK_KEY, 0, '1, 0, 0, 0, 0);
    send(REQ_REM_KEY, 0, 64'd9, 0, 0, 0, 0);
    send(REQ_REM_ID, {32'd1, 32'd1}, 0, 0, 0, 0, 0);
    send(REQ_LOOK_ID, {32'd1, 32'd40}, 0, 0, 0, 0, 0);
    send(3'd7, '1, '1, '1, '1, '1, '1);
    drain();

    write_generation(32'hFFFF_FFFF);
    send(REQ_RESTORE, '1, 64'd77, 1, 1, 32'hFFFF_FFFE, 0);
    send(REQ_RESTORE, {32'hFFFF_FFFF, 32'hFFFF_FFFE}, 64'd77, 1, 1, 32'hFFFF_FFFF, 0);
    send(REQ_ADD, 0, 64'd78, 1, 1, 0, 0);
    send(REQ_RESTORE, '1, 64'd79, 1, 1, 32'hFFFF_FFFF, 0);
    send(REQ_ADD, 0, 64'd80, 1, 1, 0, 0);
    drain();

    write_generation(32'd0);
    phase(150, 0, 0);
    drain();

    // fill the table to hit the full case
    for (int i = 0; i < ENTRIES + 4; i++)
      send(REQ_RESTORE, {32'd1, 32'(1000 + i)}, 64'(5000 + i), 1, 1, 1, 0);
    drain();

    write_generation(32'd1);
    hold_off = 1;
    fork
      phase(20, 0, 0);
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
    join
    phase(200, 76, 0);
    drain();

    write_generation($urandom | 32'd1);
    phase(200, 0, 76);
    drain();

    write_generation(32'h8000_0000);
    phase(200, 34, 34);
    phase(200, 0, 0);
    drain();

    $display("covered %0d requests, %0d result words, generation and index extremes,",
             sent, sb.checked);
    $display("full table, long output hold-off and idling on both channels");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
